[rtl/gas_pkg.sv]
// ----------------------------------------------------------------------------
// gas_pkg
// Shared types, constants and helper functions of the grid A* search unit.
// ----------------------------------------------------------------------------
package gas_pkg;

    localparam int MAX_ROWS  = 8;
    localparam int MAX_COLS  = 8;
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int CELLS     = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W    = ROW_W + COL_W;
    localparam int CNT_W     = ADDR_W + 1;
    localparam int DIM_W     = 4;
    localparam int ROW_LIMIT = (MAX_ROWS < 8) ? MAX_ROWS : 8;
    localparam int COL_LIMIT = (MAX_COLS < 8) ? MAX_COLS : 8;
    localparam int G_W       = CNT_W;
    localparam int H_W       = ROW_W + 1;
    localparam int F_W       = G_W + 1;

    localparam logic [2:0] CS_EMPTY    = 3'd0;
    localparam logic [2:0] CS_OBSTACLE = 3'd1;
    localparam logic [2:0] CS_CLOSED   = 3'd2;
    localparam logic [2:0] CS_PATH     = 3'd3;
    localparam logic [2:0] CS_START    = 3'd4;
    localparam logic [2:0] CS_FINISH   = 3'd5;

    localparam logic [2:0] REG_ROWS_USED = 3'd0;
    localparam logic [2:0] REG_COLS_USED = 3'd1;
    localparam logic [2:0] REG_START_ROW = 3'd2;
    localparam logic [2:0] REG_START_COL = 3'd3;
    localparam logic [2:0] REG_GOAL_ROW  = 3'd4;
    localparam logic [2:0] REG_GOAL_COL  = 3'd5;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_LEFT  = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [G_W-1:0]   g;
        logic [H_W-1:0]   h;
    } node_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_COPY,
        OP_START,
        OP_SCAN_RD,
        OP_SCAN_CMP,
        OP_POP,
        OP_NB_RD,
        OP_NB_NEXT,
        OP_NB_CHK,
        OP_MARK_S,
        OP_MARK_F,
        OP_OUT_RD,
        OP_OUT_LD,
        OP_NOTFOUND,
        OP_OUT_ADV
    } dp_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_COPY,
        S_START,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DECIDE,
        S_POP,
        S_NB,
        S_NB_CHK,
        S_MARK_S,
        S_MARK_F,
        S_OUT_RD,
        S_OUT_LD,
        S_SEND,
        S_NOTFOUND
    } state_t;

    typedef struct packed {
        logic   in_ready;
        logic   out_valid;
        dp_op_t op;
    } cmd_t;

    typedef struct packed {
        logic start_req;
        logic copy_last;
        logic range_bad;
        logic scan_last;
        logic have_best;
        logic is_goal;
        logic nb_ok;
        logic nb_last;
        logic out_last;
    } status_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
        return {row, col};
    endfunction

    function automatic logic [H_W-1:0] manhattan(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c,
                                                  input logic [ROW_W-1:0] gr,
                                                  input logic [COL_W-1:0] gc);
        logic [ROW_W-1:0] dr;
        logic [COL_W-1:0] dc;
        dr = (r > gr) ? (r - gr) : (gr - r);
        dc = (c > gc) ? (c - gc) : (gc - c);
        return H_W'(dr) + H_W'(dc);
    endfunction

endpackage

[rtl/gas_ctrl.sv]
// ----------------------------------------------------------------------------
// gas_ctrl
// Controller state machine that sequences map copy, search and result output.
// ----------------------------------------------------------------------------
module gas_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  gas_pkg::status_t status,
    input  logic             m_tready,
    output gas_pkg::cmd_t    cmd
);
    import gas_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (status.start_req)
                begin
                    state_next = S_COPY;
                end
            end
            S_COPY:
            begin
                if (status.copy_last)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                state_next = status.range_bad ? S_NOTFOUND : S_SCAN_RD;
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                state_next = status.scan_last ? S_DECIDE : S_SCAN_RD;
            end
            S_DECIDE:
            begin
                state_next = status.have_best ? S_POP : S_NOTFOUND;
            end
            S_POP:
            begin
                state_next = status.is_goal ? S_MARK_S : S_NB;
            end
            S_NB:
            begin
                if (status.nb_ok)
                begin
                    state_next = S_NB_CHK;
                end
                else if (status.nb_last)
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_NB_CHK:
            begin
                state_next = status.nb_last ? S_SCAN_RD : S_NB;
            end
            S_MARK_S:
            begin
                state_next = S_MARK_F;
            end
            S_MARK_F:
            begin
                state_next = S_OUT_RD;
            end
            S_OUT_RD:
            begin
                state_next = S_OUT_LD;
            end
            S_OUT_LD:
            begin
                state_next = S_SEND;
            end
            S_NOTFOUND:
            begin
                state_next = S_SEND;
            end
            S_SEND:
            begin
                if (m_tready)
                begin
                    state_next = status.out_last ? S_IDLE : S_OUT_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.in_ready  = 1'b0;
        cmd.out_valid = 1'b0;
        cmd.op        = OP_NONE;
        case (state_reg)
            S_IDLE:     cmd.in_ready = 1'b1;
            S_COPY:     cmd.op = OP_COPY;
            S_START:    cmd.op = status.range_bad ? OP_NONE : OP_START;
            S_SCAN_RD:  cmd.op = OP_SCAN_RD;
            S_SCAN_CMP: cmd.op = OP_SCAN_CMP;
            S_POP:      cmd.op = OP_POP;
            S_NB:       cmd.op = status.nb_ok ? OP_NB_RD : OP_NB_NEXT;
            S_NB_CHK:   cmd.op = OP_NB_CHK;
            S_MARK_S:   cmd.op = OP_MARK_S;
            S_MARK_F:   cmd.op = OP_MARK_F;
            S_OUT_RD:   cmd.op = OP_OUT_RD;
            S_OUT_LD:   cmd.op = OP_OUT_LD;
            S_NOTFOUND: cmd.op = OP_NOTFOUND;
            S_SEND:
            begin
                cmd.out_valid = 1'b1;
                cmd.op        = m_tready ? OP_OUT_ADV : OP_NONE;
            end
            default:    cmd.op = OP_NONE;
        endcase
    end

endmodule

[rtl/gas_dp.sv]
// ----------------------------------------------------------------------------
// gas_dp
// Datapath: configuration, obstacle map, work grid and open list memories,
// best-node scan, neighbor expansion and the output register.
// ----------------------------------------------------------------------------
module gas_dp
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  gas_pkg::cmd_t                 cmd,
    output gas_pkg::status_t              status,
    input  logic                          cfg_valid,
    input  logic [2:0]                    cfg_index,
    input  logic [gas_pkg::DIM_W-1:0]     cfg_data,
    input  logic                          s_tvalid,
    input  logic [7:0]                    s_tdata,
    input  logic                          s_tlast,
    output logic [15:0]                   m_tdata,
    output logic                          m_tuser,
    output logic                          m_tlast
);
    import gas_pkg::*;

    logic [DIM_W-1:0] rows_cfg_reg;
    logic [DIM_W-1:0] cols_cfg_reg;
    logic [ROW_W-1:0] start_row_reg;
    logic [COL_W-1:0] start_col_reg;
    logic [ROW_W-1:0] goal_row_reg;
    logic [COL_W-1:0] goal_col_reg;
    logic [DIM_W-1:0] rows_eff;
    logic [DIM_W-1:0] cols_eff;

    logic [CELLS-1:0] obst_reg;
    logic [CELLS-1:0] removed_reg;
    logic [CNT_W-1:0] push_cnt_reg;
    logic [CNT_W-1:0] idx_reg;
    logic             have_reg;
    logic [1:0]       nb_reg;
    logic [ROW_W-1:0] orow_reg;
    logic [COL_W-1:0] ocol_reg;

    logic [2:0]        grid_mem [CELLS];
    node_t             open_mem [CELLS];
    logic [2:0]        grid_rd_reg;
    node_t             open_rd_reg;
    node_t             cur_reg;
    logic [ADDR_W-1:0] best_reg;
    logic [F_W-1:0]    bf_reg;

    logic [2:0] out_state_reg;
    logic [ROW_W-1:0] out_row_reg;
    logic [COL_W-1:0] out_col_reg;
    logic       out_found_reg;
    logic       out_last_reg;

    logic [ROW_W-1:0]  in_row;
    logic [COL_W-1:0]  in_col;
    logic              in_blocked;
    logic              in_accept;
    logic [ROW_W-1:0]  nrow;
    logic [COL_W-1:0]  ncol;
    logic              nb_ok;
    logic [ADDR_W-1:0] naddr;
    logic [F_W-1:0]    rd_f;
    logic              take;

    logic              grid_we;
    logic [ADDR_W-1:0] grid_wa;
    logic [2:0]        grid_wd;
    logic [ADDR_W-1:0] grid_ra;
    logic              open_we;
    logic [ADDR_W-1:0] open_wa;
    node_t             open_wd;

    assign in_row     = s_tdata[ROW_W-1:0];
    assign in_col     = s_tdata[ROW_W+COL_W-1:ROW_W];
    assign in_blocked = s_tdata[ROW_W+COL_W];
    assign in_accept  = s_tvalid && cmd.in_ready;

    always_comb
    begin
        if (rows_cfg_reg == '0)
            rows_eff = DIM_W'(1);
        else if (rows_cfg_reg > DIM_W'(ROW_LIMIT))
            rows_eff = DIM_W'(ROW_LIMIT);
        else
            rows_eff = rows_cfg_reg;
        if (cols_cfg_reg == '0)
            cols_eff = DIM_W'(1);
        else if (cols_cfg_reg > DIM_W'(COL_LIMIT))
            cols_eff = DIM_W'(COL_LIMIT);
        else
            cols_eff = cols_cfg_reg;
    end

    always_comb
    begin
        nrow = cur_reg.row;
        ncol = cur_reg.col;
        nb_ok = 1'b0;
        case (nb_reg)
            DIR_UP:
            begin
                nrow = cur_reg.row - ROW_W'(1);
                nb_ok = (cur_reg.row != '0);
            end
            DIR_LEFT:
            begin
                ncol = cur_reg.col - COL_W'(1);
                nb_ok = (cur_reg.col != '0);
            end
            DIR_DOWN:
            begin
                nrow = cur_reg.row + ROW_W'(1);
                nb_ok = ((DIM_W'(cur_reg.row) + DIM_W'(1)) < rows_eff);
            end
            DIR_RIGHT:
            begin
                ncol = cur_reg.col + COL_W'(1);
                nb_ok = ((DIM_W'(cur_reg.col) + DIM_W'(1)) < cols_eff);
            end
            default:
            begin
                nb_ok = 1'b0;
            end
        endcase
    end

    assign naddr = cell_addr(nrow, ncol);
    assign rd_f  = F_W'(open_rd_reg.g) + F_W'(open_rd_reg.h);
    assign take  = !removed_reg[idx_reg[ADDR_W-1:0]] && (!have_reg || (rd_f <= bf_reg));

    assign status.nb_ok     = nb_ok;
    assign status.start_req = s_tvalid && s_tlast;
    assign status.copy_last = (idx_reg[ADDR_W-1:0] == ADDR_W'(CELLS - 1));
    assign status.range_bad = (DIM_W'(start_row_reg) >= rows_eff)
                           || (DIM_W'(start_col_reg) >= cols_eff)
                           || (DIM_W'(goal_row_reg) >= rows_eff)
                           || (DIM_W'(goal_col_reg) >= cols_eff);
    assign status.scan_last = ((idx_reg + CNT_W'(1)) == push_cnt_reg);
    assign status.have_best = have_reg;
    assign status.is_goal   = (cur_reg.row == goal_row_reg) && (cur_reg.col == goal_col_reg);
    assign status.nb_last   = (nb_reg == DIR_RIGHT);
    assign status.out_last  = out_last_reg;

    always_comb
    begin
        grid_we = 1'b0;
        grid_wa = '0;
        grid_wd = CS_EMPTY;
        open_we = 1'b0;
        open_wa = '0;
        open_wd = '0;
        case (cmd.op)
            OP_COPY:
            begin
                grid_we = 1'b1;
                grid_wa = idx_reg[ADDR_W-1:0];
                grid_wd = obst_reg[idx_reg[ADDR_W-1:0]] ? CS_OBSTACLE : CS_EMPTY;
            end
            OP_START:
            begin
                grid_we   = 1'b1;
                grid_wa   = cell_addr(start_row_reg, start_col_reg);
                grid_wd   = CS_CLOSED;
                open_we   = 1'b1;
                open_wa   = '0;
                open_wd.row = start_row_reg;
                open_wd.col = start_col_reg;
                open_wd.g   = '0;
                open_wd.h   = manhattan(start_row_reg, start_col_reg,
                                        goal_row_reg, goal_col_reg);
            end
            OP_POP:
            begin
                grid_we = 1'b1;
                grid_wa = cell_addr(cur_reg.row, cur_reg.col);
                grid_wd = CS_PATH;
            end
            OP_NB_CHK:
            begin
                if (grid_rd_reg == CS_EMPTY)
                begin
                    grid_we     = 1'b1;
                    grid_wa     = naddr;
                    grid_wd     = CS_CLOSED;
                    open_we     = 1'b1;
                    open_wa     = push_cnt_reg[ADDR_W-1:0];
                    open_wd.row = nrow;
                    open_wd.col = ncol;
                    open_wd.g   = cur_reg.g + G_W'(1);
                    open_wd.h   = manhattan(nrow, ncol, goal_row_reg, goal_col_reg);
                end
            end
            OP_MARK_S:
            begin
                grid_we = 1'b1;
                grid_wa = cell_addr(start_row_reg, start_col_reg);
                grid_wd = CS_START;
            end
            OP_MARK_F:
            begin
                grid_we = 1'b1;
                grid_wa = cell_addr(goal_row_reg, goal_col_reg);
                grid_wd = CS_FINISH;
            end
            default:
            begin
                grid_we = 1'b0;
            end
        endcase
    end

    assign grid_ra = (cmd.op == OP_OUT_RD) ? cell_addr(orow_reg, ocol_reg) : naddr;

    always_ff @(posedge clk)
    begin
        if (grid_we)
        begin
            grid_mem[grid_wa] <= grid_wd;
        end
        if ((cmd.op == OP_NB_RD) || (cmd.op == OP_OUT_RD))
        begin
            grid_rd_reg <= grid_mem[grid_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (open_we)
        begin
            open_mem[open_wa] <= open_wd;
        end
        if (cmd.op == OP_SCAN_RD)
        begin
            open_rd_reg <= open_mem[idx_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg  <= DIM_W'(8);
            cols_cfg_reg  <= DIM_W'(8);
            start_row_reg <= '0;
            start_col_reg <= '0;
            goal_row_reg  <= '0;
            goal_col_reg  <= '0;
            obst_reg      <= '0;
            removed_reg   <= '0;
            push_cnt_reg  <= '0;
            idx_reg       <= '0;
            have_reg      <= 1'b0;
            nb_reg        <= DIR_UP;
            orow_reg      <= '0;
            ocol_reg      <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_ROWS_USED: rows_cfg_reg  <= cfg_data;
                    REG_COLS_USED: cols_cfg_reg  <= cfg_data;
                    REG_START_ROW: start_row_reg <= cfg_data[ROW_W-1:0];
                    REG_START_COL: start_col_reg <= cfg_data[COL_W-1:0];
                    REG_GOAL_ROW:  goal_row_reg  <= cfg_data[ROW_W-1:0];
                    REG_GOAL_COL:  goal_col_reg  <= cfg_data[COL_W-1:0];
                    default:       rows_cfg_reg  <= rows_cfg_reg;
                endcase
            end
            if (in_accept)
            begin
                if ((DIM_W'(in_row) < DIM_W'(MAX_ROWS)) && (DIM_W'(in_col) < DIM_W'(MAX_COLS)))
                begin
                    obst_reg[cell_addr(in_row, in_col)] <= in_blocked;
                end
                if (s_tlast)
                begin
                    idx_reg     <= '0;
                    removed_reg <= '0;
                end
            end
            case (cmd.op)
                OP_COPY:
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                end
                OP_START:
                begin
                    push_cnt_reg <= CNT_W'(1);
                    idx_reg      <= '0;
                    have_reg     <= 1'b0;
                end
                OP_SCAN_CMP:
                begin
                    if (take)
                    begin
                        have_reg <= 1'b1;
                    end
                    idx_reg <= idx_reg + CNT_W'(1);
                end
                OP_POP:
                begin
                    removed_reg[best_reg] <= 1'b1;
                    idx_reg  <= '0;
                    have_reg <= 1'b0;
                    nb_reg   <= DIR_UP;
                end
                OP_NB_NEXT:
                begin
                    nb_reg <= nb_reg + 2'd1;
                end
                OP_NB_CHK:
                begin
                    if (grid_rd_reg == CS_EMPTY)
                    begin
                        push_cnt_reg <= push_cnt_reg + CNT_W'(1);
                    end
                    nb_reg <= nb_reg + 2'd1;
                end
                OP_MARK_F:
                begin
                    orow_reg <= '0;
                    ocol_reg <= '0;
                end
                OP_OUT_ADV:
                begin
                    if ((DIM_W'(ocol_reg) + DIM_W'(1)) == cols_eff)
                    begin
                        ocol_reg <= '0;
                        orow_reg <= orow_reg + ROW_W'(1);
                    end
                    else
                    begin
                        ocol_reg <= ocol_reg + COL_W'(1);
                    end
                end
                default:
                begin
                    have_reg <= have_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_SCAN_CMP:
            begin
                if (take)
                begin
                    best_reg <= idx_reg[ADDR_W-1:0];
                    bf_reg   <= rd_f;
                    cur_reg  <= open_rd_reg;
                end
            end
            OP_OUT_LD:
            begin
                out_found_reg <= 1'b1;
                out_row_reg   <= orow_reg;
                out_col_reg   <= ocol_reg;
                out_state_reg <= grid_rd_reg;
                out_last_reg  <= ((DIM_W'(orow_reg) + DIM_W'(1)) == rows_eff)
                              && ((DIM_W'(ocol_reg) + DIM_W'(1)) == cols_eff);
            end
            OP_NOTFOUND:
            begin
                out_found_reg <= 1'b0;
                out_row_reg   <= '0;
                out_col_reg   <= '0;
                out_state_reg <= CS_EMPTY;
                out_last_reg  <= 1'b1;
            end
            default:
            begin
                out_found_reg <= out_found_reg;
            end
        endcase
    end

    assign m_tdata = {7'd0, out_state_reg, out_col_reg, out_row_reg};
    assign m_tuser = out_found_reg;
    assign m_tlast = out_last_reg;

endmodule

[rtl/grid_astar_search_unit.sv]
// ----------------------------------------------------------------------------
// grid_astar_search_unit
// A* path search on a four-connected grid of up to 8 x 8 cells.
// ----------------------------------------------------------------------------
// Map load transfers are taken one per cycle while the unit is idle and write
// one cell of the stored obstacle map. The transfer with tlast set also starts
// a search, and input stays stalled until every result has been transferred.
// A search first copies the map into the work grid, then for each popped node
// scans the open list over every entry pushed so far, reading and then
// comparing each one, and checks the four neighbors in turn. Each result cell
// is read from the grid, loaded into the output register and held until taken.
module grid_astar_search_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [3:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // cell_row[2:0], cell_col[5:3], blocked[6], zero[7]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // out_row[2:0], out_col[5:3], cell_state[8:6], zero
    output logic        m_tuser,   // found[0]
    output logic        m_tlast
);
    import gas_pkg::*;

    cmd_t    cmd;
    status_t status;

    gas_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .status   (status),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    gas_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = cmd.in_ready;
    assign m_tvalid  = cmd.out_valid;

endmodule

[tb/sv/tb_grid_astar_search_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_grid_astar_search_unit
// Self-checking testbench of the grid A* search unit.
// ----------------------------------------------------------------------------
// Map cells are loaded over the input stream, and a transfer with tlast set
// starts a search. A behavioral A* search predicts every result transfer,
// and a scoreboard compares each one field by field. Grid size, start and
// goal are reprogrammed between phases while the block is idle. The sender
// works in bursts, and the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module tb_grid_astar_search_unit;
    import gas_pkg::*;

    typedef struct packed {
        logic       found;
        logic [2:0] row;
        logic [2:0] col;
        logic [2:0] state;
        logic       last;
    } cell_report_t;

    class search_scoreboard;
        logic         obstacle [CELLS];
        logic [2:0]   grid [CELLS];
        logic [3:0]   regs [6];
        cell_report_t pending [$];
        int           mismatches;
        int           checked;
        int           searches;
        int           found_count;

        function void clear();
            foreach (obstacle[i]) obstacle[i] = 1'b0;
            regs[0] = 4'd8;
            regs[1] = 4'd8;
            for (int i = 2; i < 6; i++) regs[i] = 4'd0;
            mismatches = 0;
            checked = 0;
            searches = 0;
            found_count = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [3:0] value);
            if (idx < 2) regs[idx] = value;
            else if (idx < 6) regs[idx] = {1'b0, value[2:0]};
        endfunction

        function int dim(logic [3:0] v);
            if (v == 0) return 1;
            if (v > 8) return 8;
            return v;
        endfunction

        function int absdiff(int a, int b);
            return (a > b) ? a - b : b - a;
        endfunction

        function bit search(int rows, int cols);
            int sr, sc, gr, gc, best, bf, f, nr, nc;
            int qr [$];
            int qc [$];
            int qg [$];
            int qh [$];
            int cr, cc, cg;
            int dr [4] = '{-1, 0, 1, 0};
            int dc [4] = '{0, -1, 0, 1};
            sr = regs[2];
            sc = regs[3];
            gr = regs[4];
            gc = regs[5];
            foreach (grid[i]) grid[i] = obstacle[i] ? CS_OBSTACLE : CS_EMPTY;
            if (sr >= rows || sc >= cols || gr >= rows || gc >= cols) return 0;
            qr.insert(qr.size(), sr);
            qc.insert(qc.size(), sc);
            qg.insert(qg.size(), 0);
            qh.insert(qh.size(), absdiff(sr, gr) + absdiff(sc, gc));
            grid[sr * MAX_COLS + sc] = CS_CLOSED;
            while (qr.size() > 0) begin
                best = 0;
                bf = qg[0] + qh[0];
                for (int i = 1; i < qr.size(); i++)
                begin
                    f = qg[i] + qh[i];
                    if (f <= bf)
                    begin
                        bf = f;
                        best = i;
                    end
                end
                cr = qr[best];
                cc = qc[best];
                cg = qg[best];
                qr.delete(best);
                qc.delete(best);
                qg.delete(best);
                qh.delete(best);
                grid[cr * MAX_COLS + cc] = CS_PATH;
                if (cr == gr && cc == gc)
                begin
                    grid[sr * MAX_COLS + sc] = CS_START;
                    grid[gr * MAX_COLS + gc] = CS_FINISH;
                    return 1;
                end
                for (int d = 0; d < 4; d++)
                begin
                    nr = cr + dr[d];
                    nc = cc + dc[d];
                    if (nr < 0 || nc < 0 || nr >= rows || nc >= cols) continue;
                    if (grid[nr * MAX_COLS + nc] != CS_EMPTY) continue;
                    qr.insert(qr.size(), nr);
                    qc.insert(qc.size(), nc);
                    qg.insert(qg.size(), cg + 1);
                    qh.insert(qh.size(), absdiff(nr, gr) + absdiff(nc, gc));
                    grid[nr * MAX_COLS + nc] = CS_CLOSED;
                end
            end
            return 0;
        endfunction

        function void note_load(logic [2:0] r, logic [2:0] c, logic b, logic go);
            int rows, cols;
            cell_report_t e;
            obstacle[r * MAX_COLS + c] = b;
            if (!go) return;
            searches++;
            rows = dim(regs[0]);
            cols = dim(regs[1]);
            if (!search(rows, cols))
            begin
                e = '{1'b0, 3'd0, 3'd0, CS_EMPTY, 1'b1};
                pending.insert(pending.size(), e);
                return;
            end
            found_count++;
            for (int i = 0; i < rows; i++)
                for (int j = 0; j < cols; j++)
                begin
                    e.found = 1'b1;
                    e.row = 3'(i);
                    e.col = 3'(j);
                    e.state = grid[i * MAX_COLS + j];
                    e.last = (i == rows - 1 && j == cols - 1);
                    pending.insert(pending.size(), e);
                end
        endfunction

        function void check_result(cell_report_t got);
            cell_report_t e;
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result transfer %p", got);
                return;
            end
            e = pending.pop_front();
            if (got !== e)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected %p, got %p", e, got);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [3:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    search_scoreboard sb;
    int idle_cycles;
    int stall_phase;
    int gap_left;
    int burst_left;
    int sent_count;

    grid_astar_search_unit i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        stall_phase <= stall_phase + 1;
        if (stall_phase % 200 < 60) m_tready <= 1'b1;
        else m_tready <= ((stall_phase % 7) != 3) && ($urandom_range(0, 3) != 0);
        if (rst_n && m_tvalid && m_tready)
            sb.check_result('{m_tuser, m_tdata[2:0], m_tdata[5:3], m_tdata[8:6], m_tlast});
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 60000)
        begin
            $display("Watchdog expired");
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [3:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, value);
    endtask

    task automatic send_cell(logic [2:0] r, logic [2:0] c, logic b, logic go);
        if (gap_left > 0)
        begin
            repeat (gap_left) @(posedge clk);
            gap_left = 0;
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, b, c, r};
        s_tlast <= go;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_load(r, c, b, go);
        sent_count++;
        if (burst_left > 0) burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end
        if (go || gap_left > 0) s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        int n;
        n = 0;
        while (sb.pending.size() > 0) @(posedge clk);
        while (n < 20)
        begin
            @(posedge clk);
            n++;
        end
    endtask

    task automatic set_job(int rows, int cols, int sr, int scol, int gr, int gcol);
        if (gap_left == 0) s_tvalid <= 1'b0;
        write_reg(REG_ROWS_USED, 4'(rows));
        write_reg(REG_COLS_USED, 4'(cols));
        write_reg(REG_START_ROW, 4'(sr));
        write_reg(REG_START_COL, 4'(scol));
        write_reg(REG_GOAL_ROW, 4'(gr));
        write_reg(REG_GOAL_COL, 4'(gcol));
        cfg_valid <= 1'b0;
    endtask

    task automatic random_map(int rows, int cols, int density);
        int n;
        n = $urandom_range(1, 2 * rows * cols);
        for (int i = 0; i < n; i++)
            send_cell(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                      $urandom_range(0, 99) < density, 1'b0);
        send_cell(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                  $urandom_range(0, 99) < density, 1'b1);
        drain();
    endtask

    initial
    begin
        int rows, cols;
        sb = new();
        sb.clear();
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_ROWS_USED;
        cfg_data = 4'd0;
        s_tvalid = 1'b0;
        s_tdata = 8'd0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        stall_phase = 0;
        idle_cycles = 0;
        gap_left = 0;
        burst_left = 0;
        sent_count = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Start equal to goal on an empty full grid.
        send_cell(3'd7, 3'd7, 1'b0, 1'b1);
        drain();
        set_job(8, 8, 0, 0, 7, 7);
        send_cell(3'd0, 3'd0, 1'b1, 1'b0);
        send_cell(3'd7, 3'd7, 1'b1, 1'b0);
        send_cell(3'd7, 3'd7, 1'b0, 1'b1);
        drain();
        // Wall cutting the grid off gives no path.
        for (int i = 0; i < 8; i++) send_cell(3'(i), 3'd4, 1'b1, i == 7);
        drain();
        for (int i = 0; i < 8; i++) send_cell(3'(i), 3'd4, 1'b0, 1'b0);
        set_job(0, 15, 0, 7, 0, 0);
        send_cell(3'd0, 3'd0, 1'b0, 1'b1);
        drain();
        set_job(1, 1, 7, 0, 0, 0);
        send_cell(3'd5, 3'd2, 1'b1, 1'b1);
        drain();
        set_job(2, 8, 1, 7, 0, 0);
        send_cell(3'd5, 3'd2, 1'b0, 1'b1);
        drain();

        while (sent_count < 290)
        begin
            if ($urandom_range(0, 3) == 0) rows = $urandom_range(0, 15);
            else rows = $urandom_range(1, 4);
            cols = $urandom_range(1, 4);
            if ($urandom_range(0, 9) == 0)
                set_job(rows, $urandom_range(0, 15), $urandom_range(0, 7),
                        $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7));
            else
                set_job(rows, cols, $urandom_range(0, sb.dim(4'(rows)) - 1),
                        $urandom_range(0, cols - 1),
                        $urandom_range(0, sb.dim(4'(rows)) - 1),
                        $urandom_range(0, cols - 1));
            random_map(sb.dim(4'(rows)), sb.dim(4'(cols)), $urandom_range(5, 40));
        end

        drain();
        $display("Ran %0d searches, %0d found a path, %0d result transfers checked.",
                 sb.searches, sb.found_count, sb.checked);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
